// ===== hw/rtl/disk_erode_mask_fusion_unit_assert.svh =====
// Assertion macros shared by the disk erosion and fusion RTL.
`ifndef DISK_ERODE_MASK_FUSION_UNIT_ASSERT_SVH
`define DISK_ERODE_MASK_FUSION_UNIT_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define DEM_ASSERT_IMPLY(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define DEM_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");

`endif

// ===== hw/rtl/dem_pkg.sv =====
`default_nettype none
package dem_pkg;

   localparam logic [12:0] ONE_Q12 = 13'd4096;
   localparam int CNT_W = 26;
   localparam int DIV_NW = 26;
   localparam int DIV_DW = 20;

   localparam logic [2:0] CSR_COLUMNS = 3'd0;
   localparam logic [2:0] CSR_ROWS = 3'd1;
   localparam logic [2:0] CSR_RADIUS = 3'd2;
   localparam logic [2:0] CSR_CORE_THR = 3'd3;
   localparam logic [2:0] CSR_WEAK_THR = 3'd4;

   typedef struct packed {
      logic [12:0] cols;
      logic [12:0] rows;
      logic [3:0]  radius;
      logic [12:0] core_thr;
      logic [12:0] weak_thr;
   } cfg_type;

   // The store slots of the pixel travel with it, so the back end needs no remainder.
   typedef struct packed {
      logic             is_pass;
      logic             eof;
      logic [15:0]      value;
      logic [25:0]      index;
      logic [CNT_W-1:0] sec_slot;
      logic [CNT_W-1:0] pri_slot;
   } job_type;

   typedef struct packed {
      logic [15:0] fused;
      logic        eof;
   } result_type;

   function automatic logic [12:0] clamp_q12(input logic [15:0] v);
      logic [12:0] r;
      if (v[15]) begin
         r = '0;
      end else if (v[14:0] > 15'd4096) begin
         r = ONE_Q12;
      end else begin
         r = v[12:0];
      end
      return r;
   endfunction

   function automatic logic [12:0] clamp_thr(input logic [12:0] v);
      return (v > ONE_Q12) ? ONE_Q12 : v;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/dem_ram.sv =====
`default_nettype none
module dem_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/dem_fifo.sv =====
`default_nettype none
module dem_fifo #(
   parameter int WIDTH = 8,
   parameter int ADDR_W = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      head,
   output logic                  empty,
   output logic                  full
);
   localparam int DEPTH = 1 << ADDR_W;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [ADDR_W:0]  wptr_ff, wptr_in;
   logic [ADDR_W:0]  rptr_ff, rptr_in;

   assign empty = (wptr_ff == rptr_ff);
   assign full = (wptr_ff[ADDR_W] != rptr_ff[ADDR_W]) &&
                 (wptr_ff[ADDR_W-1:0] == rptr_ff[ADDR_W-1:0]);
   assign head = slot_ff[rptr_ff[ADDR_W-1:0]];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      if (push && !full) begin
         wptr_in = wptr_ff + 1'b1;
      end
      if (pop && !empty) begin
         rptr_in = rptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
      end
      if (push && !full) begin
         slot_ff[wptr_ff[ADDR_W-1:0]] <= push_data;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/dem_div.sv =====
`default_nettype none
module dem_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [dem_pkg::DIV_NW-1:0]  numer,
   input  wire logic [dem_pkg::DIV_DW-1:0]  denom,
   output logic                             busy,
   output logic                             done,
   output logic [dem_pkg::DIV_NW-1:0]       quotient,
   output logic [dem_pkg::DIV_DW-1:0]       remainder
);
   import dem_pkg::*;

   logic [DIV_NW-1:0] quo_ff, quo_in;
   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_DW-1:0] den_ff, den_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_DW:0]   trial;

   assign busy = busy_ff;
   assign done = done_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff;

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff, quo_ff[DIV_NW-1]};
      if (start && !busy_ff) begin
         quo_in = numer;
         rem_in = '0;
         den_in = denom;
         cnt_in = 5'(DIV_NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIV_DW'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[DIV_NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DW-1:0];
            quo_in = {quo_ff[DIV_NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end
endmodule
`default_nettype wire

// ===== hw/rtl/dem_front.sv =====
`default_nettype none
module dem_front #(
   parameter int MAX_SIDE = 768,
   parameter int SEC_DEPTH = 23808,
   parameter int PRI_DEPTH = 11536
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire dem_pkg::cfg_type             cfg,
   input  wire logic                         accept,
   input  wire logic                         mode,
   input  wire logic [15:0]                  primary_alpha,
   input  wire logic [15:0]                  secondary_alpha,
   output logic                              job_push,
   output dem_pkg::job_type                  job,
   output logic                              sec_we,
   output logic [$clog2(SEC_DEPTH)-1:0]      sec_waddr,
   output logic [12:0]                       sec_wdata,
   output logic                              pri_we,
   output logic [$clog2(PRI_DEPTH)-1:0]      pri_waddr,
   output logic [15:0]                       pri_wdata
);
   import dem_pkg::*;

   localparam int SAW = $clog2(SEC_DEPTH);
   localparam int PAW = $clog2(PRI_DEPTH);

   logic [CNT_W-1:0] n_ff;
   logic [17:0]      rw1_ff;
   logic [CNT_W-1:0] ic_ff, ic_in, oc_ff, oc_in;
   logic [SAW-1:0]   isec_ff, isec_in, osec_ff, osec_in;
   logic [PAW-1:0]   ipri_ff, ipri_in, opri_ff, opri_in;

   logic             restart, pass, wr, last;
   logic [CNT_W-1:0] ic0, oc0, ic1, oc_next;
   logic [SAW-1:0]   isec0, osec0;
   logic [PAW-1:0]   ipri0, opri0;
   logic [CNT_W:0]   need;

   function automatic logic [SAW-1:0] sec_inc(input logic [SAW-1:0] a);
      return (a == SAW'(SEC_DEPTH - 1)) ? '0 : a + 1'b1;
   endfunction

   function automatic logic [PAW-1:0] pri_inc(input logic [PAW-1:0] a);
      return (a == PAW'(PRI_DEPTH - 1)) ? '0 : a + 1'b1;
   endfunction

   assign pass = (cfg.cols > 13'(MAX_SIDE)) || (cfg.rows > 13'(MAX_SIDE));
   assign sec_wdata = clamp_q12(secondary_alpha);
   assign pri_wdata = primary_alpha;

   always_comb begin
      // A frame that shrank below the counters, or a finished frame, restarts.
      restart = (oc_ff >= n_ff) || (ic_ff > n_ff);
      ic0 = restart ? '0 : ic_ff;
      oc0 = restart ? '0 : oc_ff;
      isec0 = restart ? '0 : isec_ff;
      osec0 = restart ? '0 : osec_ff;
      ipri0 = restart ? '0 : ipri_ff;
      opri0 = restart ? '0 : opri_ff;
      oc_next = oc0 + 1'b1;
      last = (oc_next == n_ff);
      wr = 1'b0;
      ic1 = ic0;
      need = '0;

      ic_in = ic_ff;
      oc_in = oc_ff;
      isec_in = isec_ff;
      osec_in = osec_ff;
      ipri_in = ipri_ff;
      opri_in = opri_ff;
      job_push = 1'b0;
      job = '0;
      job.value = primary_alpha;
      job.index = oc0;
      job.eof = last;
      job.sec_slot = CNT_W'(osec0);
      job.pri_slot = CNT_W'(opri0);
      sec_we = 1'b0;
      pri_we = 1'b0;
      sec_waddr = isec0;
      pri_waddr = ipri0;

      if (accept) begin
         ic_in = ic0;
         oc_in = oc0;
         isec_in = isec0;
         osec_in = osec0;
         ipri_in = ipri0;
         opri_in = opri0;
         if (pass) begin
            if (!mode) begin
               job_push = 1'b1;
               job.is_pass = 1'b1;
               if (last) begin
                  oc_in = '0;
                  osec_in = '0;
                  opri_in = '0;
               end else begin
                  oc_in = oc_next;
                  osec_in = sec_inc(osec0);
                  opri_in = pri_inc(opri0);
               end
               ic_in = oc_in;
               isec_in = osec_in;
               ipri_in = opri_in;
            end
         end else begin
            wr = !mode && (ic0 < n_ff);
            if (wr) begin
               ic1 = ic0 + 1'b1;
               sec_we = 1'b1;
               pri_we = 1'b1;
               isec_in = sec_inc(isec0);
               ipri_in = pri_inc(ipri0);
            end
            ic_in = ic1;
            need = {1'b0, oc0} + (CNT_W + 1)'(rw1_ff);
            if (need > {1'b0, n_ff}) begin
               need = {1'b0, n_ff};
            end
            if ((oc0 < ic1) && ({1'b0, ic1} >= need)) begin
               job_push = 1'b1;
               if (last) begin
                  oc_in = '0;
                  ic_in = '0;
                  osec_in = '0;
                  opri_in = '0;
                  isec_in = '0;
                  ipri_in = '0;
               end else begin
                  oc_in = oc_next;
                  osec_in = sec_inc(osec0);
                  opri_in = pri_inc(opri0);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ic_ff <= '0;
         oc_ff <= '0;
         isec_ff <= '0;
         osec_ff <= '0;
         ipri_ff <= '0;
         opri_ff <= '0;
      end else begin
         ic_ff <= ic_in;
         oc_ff <= oc_in;
         isec_ff <= isec_in;
         osec_ff <= osec_in;
         ipri_ff <= ipri_in;
         opri_ff <= opri_in;
      end
      n_ff <= CNT_W'(cfg.cols * cfg.rows);
      rw1_ff <= 18'(cfg.radius * cfg.cols) + 18'(cfg.radius) + 18'd1;
   end
endmodule
`default_nettype wire

// ===== hw/rtl/dem_back.sv =====
`default_nettype none
`include "disk_erode_mask_fusion_unit_assert.svh"
module dem_back #(
   parameter int SEC_DEPTH = 23808,
   parameter int PRI_DEPTH = 11536
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire dem_pkg::cfg_type            cfg,
   input  wire logic                        job_empty,
   input  wire dem_pkg::job_type            job,
   output logic                             job_pop,
   output logic [$clog2(SEC_DEPTH)-1:0]     sec_raddr,
   input  wire logic [12:0]                 sec_rdata,
   output logic [$clog2(PRI_DEPTH)-1:0]     pri_raddr,
   input  wire logic [15:0]                 pri_rdata,
   input  wire logic                        out_full,
   output logic                             out_push,
   output dem_pkg::result_type              out_item,
   output logic                             idle
);
   import dem_pkg::*;

   localparam int SAW = $clog2(SEC_DEPTH);
   localparam int PAW = $clog2(PRI_DEPTH);

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_DIV_Y = 5'd1;
   localparam logic [4:0] ST_SETUP = 5'd4;
   localparam logic [4:0] ST_ADDR  = 5'd5;
   localparam logic [4:0] ST_SCAN  = 5'd6;
   localparam logic [4:0] ST_DRAIN = 5'd7;
   localparam logic [4:0] ST_CHECK = 5'd8;
   localparam logic [4:0] ST_DIV_C = 5'd9;
   localparam logic [4:0] ST_SQ    = 5'd10;
   localparam logic [4:0] ST_CUBE  = 5'd11;
   localparam logic [4:0] ST_DIV_W = 5'd12;
   localparam logic [4:0] ST_BLEND = 5'd13;
   localparam logic [4:0] ST_MIX_A = 5'd14;
   localparam logic [4:0] ST_MIX_B = 5'd15;
   localparam logic [4:0] ST_PUSH  = 5'd16;

   logic [4:0]        state_ff, state_in;
   logic [25:0]       k_ff, k_in;
   logic              eof_ff, eof_in;
   logic [12:0]       x_ff, x_in, y_ff, y_in;
   logic [SAW-1:0]    ksec_ff, ksec_in;
   logic [PAW-1:0]    kpri_ff, kpri_in;
   logic [12:0]       x0_ff, x0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic [12:0]       xx_ff, xx_in, yy_ff, yy_in;
   logic [3:0]        dxl_ff, dxl_in;
   logic [SAW-1:0]    prod_ff, prod_in;
   logic [SAW-1:0]    row_ff, row_in, addr_ff, addr_in;
   logic              hit_ff, hit_in;
   logic [12:0]       m_ff, m_in;
   logic [12:0]       p_ff, p_in;
   logic [12:0]       t_ff, t_in;
   logic [24:0]       sq_ff, sq_in;
   logic              phase_ff, phase_in;
   logic [12:0]       strength_ff, strength_in;
   logic [12:0]       weak_ff, weak_in;
   logic [12:0]       blend_ff, blend_in;
   logic [25:0]       mix_ff, mix_in;
   logic [15:0]       res_ff, res_in;

   logic              div_start, div_busy, div_done;
   logic [DIV_NW-1:0] div_numer, div_quo;
   logic [DIV_DW-1:0] div_denom, div_rem;

   logic [12:0]       y0, x0, y1, x1, dyu, dxl, ct, wt, pc, cap_q, target;
   logic [13:0]       ysum, xsum;
   logic [3:0]        dx4, dy4;
   logic [12:0]       dxw, dyw;
   logic [8:0]        dsq, rr;
   logic              in_disk;
   logic [SAW:0]      start_addr, row_next;
   logic [38:0]       cube;
   logic [25:0]       bprod, mprod;

   dem_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numer     (div_numer),
      .denom     (div_denom),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign idle = (state_ff == ST_IDLE);
   assign sec_raddr = addr_ff;
   assign pri_raddr = kpri_ff;
   assign out_item.fused = res_ff;
   assign out_item.eof = eof_ff;

   always_comb begin
      // Disk window, clipped at the frame edges.
      y0 = (y_ff > 13'(cfg.radius)) ? y_ff - 13'(cfg.radius) : '0;
      x0 = (x_ff > 13'(cfg.radius)) ? x_ff - 13'(cfg.radius) : '0;
      ysum = {1'b0, y_ff} + 14'(cfg.radius);
      xsum = {1'b0, x_ff} + 14'(cfg.radius);
      y1 = (ysum < {1'b0, cfg.rows}) ? ysum[12:0] : cfg.rows - 1'b1;
      x1 = (xsum < {1'b0, cfg.cols}) ? xsum[12:0] : cfg.cols - 1'b1;
      dyu = y_ff - y0;
      dxl = x_ff - x0;

      dxw = (xx_ff >= x_ff) ? xx_ff - x_ff : x_ff - xx_ff;
      dyw = (yy_ff >= y_ff) ? yy_ff - y_ff : y_ff - yy_ff;
      dx4 = dxw[3:0];
      dy4 = dyw[3:0];
      dsq = 9'(8'(dx4) * 8'(dx4)) + 9'(8'(dy4) * 8'(dy4));
      rr = 9'(8'(cfg.radius) * 8'(cfg.radius));
      in_disk = (dsq <= rr);

      // The disk's first entry lies behind the center by whole rows and columns.
      start_addr = {1'b0, ksec_ff} - {1'b0, prod_ff} - (SAW + 1)'(dxl_ff);
      if (start_addr[SAW]) begin
         start_addr = start_addr + (SAW + 1)'(SEC_DEPTH);
      end
      row_next = {1'b0, row_ff} + (SAW + 1)'(cfg.cols);
      if (row_next >= (SAW + 1)'(SEC_DEPTH)) begin
         row_next = row_next - (SAW + 1)'(SEC_DEPTH);
      end

      ct = clamp_thr(cfg.core_thr);
      wt = clamp_thr(cfg.weak_thr);
      pc = clamp_q12(pri_rdata);
      cap_q = (div_quo > 26'(ONE_Q12)) ? ONE_Q12 : div_quo[12:0];
      target = (p_ff > m_ff) ? p_ff : m_ff;
      cube = 39'(sq_ff) * 39'(14'd12288 - {t_ff, 1'b0});
      bprod = strength_ff * weak_ff;
      mprod = target * blend_ff;

      state_in = state_ff;
      k_in = k_ff;
      eof_in = eof_ff;
      x_in = x_ff;
      y_in = y_ff;
      ksec_in = ksec_ff;
      kpri_in = kpri_ff;
      x0_in = x0_ff;
      x1_in = x1_ff;
      y1_in = y1_ff;
      xx_in = xx_ff;
      yy_in = yy_ff;
      dxl_in = dxl_ff;
      prod_in = prod_ff;
      row_in = row_ff;
      addr_in = addr_ff;
      hit_in = 1'b0;
      m_in = m_ff;
      p_in = p_ff;
      t_in = t_ff;
      sq_in = sq_ff;
      phase_in = phase_ff;
      strength_in = strength_ff;
      weak_in = weak_ff;
      blend_in = blend_ff;
      mix_in = mix_ff;
      res_in = res_ff;
      job_pop = 1'b0;
      out_push = 1'b0;
      div_start = 1'b0;
      div_numer = DIV_NW'(k_ff);
      div_denom = DIV_DW'(cfg.cols);

      case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               job_pop = 1'b1;
               k_in = job.index;
               eof_in = job.eof;
               ksec_in = job.sec_slot[SAW-1:0];
               kpri_in = job.pri_slot[PAW-1:0];
               if (job.is_pass) begin
                  res_in = job.value;
                  state_in = ST_PUSH;
               end else begin
                  div_start = 1'b1;
                  div_numer = DIV_NW'(job.index);
                  state_in = ST_DIV_Y;
               end
            end
         end
         ST_DIV_Y: begin
            if (div_done) begin
               y_in = div_quo[12:0];
               x_in = div_rem[12:0];
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            x0_in = x0;
            x1_in = x1;
            y1_in = y1;
            xx_in = x0;
            yy_in = y0;
            dxl_in = dxl[3:0];
            prod_in = SAW'(dyu[3:0] * cfg.cols);
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            row_in = start_addr[SAW-1:0];
            addr_in = start_addr[SAW-1:0];
            m_in = ONE_Q12;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // Read data arrives in the cycle after its address; the hit flag follows it.
            hit_in = in_disk;
            if (hit_ff && (sec_rdata < m_ff)) begin
               m_in = sec_rdata;
            end
            if (xx_ff == x1_ff) begin
               if (yy_ff == y1_ff) begin
                  state_in = ST_DRAIN;
               end else begin
                  yy_in = yy_ff + 1'b1;
                  xx_in = x0_ff;
                  row_in = row_next[SAW-1:0];
                  addr_in = row_next[SAW-1:0];
               end
            end else begin
               xx_in = xx_ff + 1'b1;
               addr_in = (addr_ff == SAW'(SEC_DEPTH - 1)) ? '0 : addr_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (hit_ff && (sec_rdata < m_ff)) begin
               m_in = sec_rdata;
            end
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            p_in = pc;
            if ((m_ff < ct) || (pc >= wt)) begin
               res_in = 16'(pc);
               state_in = ST_PUSH;
            end else if (ct == ONE_Q12) begin
               strength_in = ONE_Q12;
               div_start = 1'b1;
               div_numer = DIV_NW'({pc, 12'd0});
               div_denom = DIV_DW'(wt);
               state_in = ST_DIV_W;
            end else begin
               div_start = 1'b1;
               div_numer = DIV_NW'({m_ff - ct, 12'd0});
               div_denom = DIV_DW'(ONE_Q12 - ct);
               state_in = ST_DIV_C;
            end
         end
         ST_DIV_C: begin
            if (div_done) begin
               t_in = cap_q;
               phase_in = 1'b0;
               state_in = ST_SQ;
            end
         end
         ST_DIV_W: begin
            if (div_done) begin
               t_in = cap_q;
               phase_in = 1'b1;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            sq_in = 25'(t_ff * t_ff);
            state_in = ST_CUBE;
         end
         ST_CUBE: begin
            if (!phase_ff) begin
               strength_in = cube[36:24];
               div_start = 1'b1;
               div_numer = DIV_NW'({p_ff, 12'd0});
               div_denom = DIV_DW'(wt);
               state_in = ST_DIV_W;
            end else begin
               weak_in = ONE_Q12 - cube[36:24];
               state_in = ST_BLEND;
            end
         end
         ST_BLEND: begin
            blend_in = (bprod[25:12] > 14'(ONE_Q12)) ? ONE_Q12 : bprod[24:12];
            state_in = ST_MIX_A;
         end
         ST_MIX_A: begin
            mix_in = p_ff * (ONE_Q12 - blend_ff);
            state_in = ST_MIX_B;
         end
         ST_MIX_B: begin
            res_in = 16'((27'(mix_ff) + 27'(mprod)) >> 12);
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (!out_full) begin
               out_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hit_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hit_ff <= hit_in;
      end
      k_ff <= k_in;
      eof_ff <= eof_in;
      x_ff <= x_in;
      y_ff <= y_in;
      ksec_ff <= ksec_in;
      kpri_ff <= kpri_in;
      x0_ff <= x0_in;
      x1_ff <= x1_in;
      y1_ff <= y1_in;
      xx_ff <= xx_in;
      yy_ff <= yy_in;
      dxl_ff <= dxl_in;
      prod_ff <= prod_in;
      row_ff <= row_in;
      addr_ff <= addr_in;
      m_ff <= m_in;
      p_ff <= p_in;
      t_ff <= t_in;
      sq_ff <= sq_in;
      phase_ff <= phase_in;
      strength_ff <= strength_in;
      weak_ff <= weak_in;
      blend_ff <= blend_in;
      mix_ff <= mix_in;
      res_ff <= res_in;
   end

   `DEM_ASSERT_IMPLY(a_div_start_idle, clock, reset, div_start, !div_busy)
   `DEM_ASSERT_IMPLY(a_core_in_range, clock, reset, state_ff == ST_CHECK, m_ff <= ONE_Q12)
   `DEM_ASSERT_NEXT(a_scan_exit, clock, reset, state_ff == ST_SCAN, state_ff == ST_SCAN || state_ff == ST_DRAIN)
endmodule
`default_nettype wire

// ===== hw/rtl/disk_erode_mask_fusion_unit.sv =====
// Disk erosion and mask fusion. Pixel pairs (primary, secondary alpha, Q3.12) enter in raster
// order through a push/full port; fused alphas leave through an empty/pop port, the oldest first.
// The secondary alpha is clamped and kept in a circular line store of
// (2*MAX_RADIUS+1)*MAX_SIDE entries, the raw primary in a delay store of
// MAX_RADIUS*MAX_SIDE+MAX_RADIUS+1 entries; neither store needs clearing after reset. A
// result is released once its whole disk has arrived; mode-1 drain items flush what is left at
// frame end. The block works on one item at a time; a pixel result's work is set by the disk
// scan, one line-store read per cycle on a single read port, plus a shared bit-serial divider
// that finds the pixel's coordinates and the two blend weights, and a result is held until
// the result queue has room. A register write is registered; the input reports full for the
// cycle after it.
`default_nettype none
`include "disk_erode_mask_fusion_unit_assert.svh"
module disk_erode_mask_fusion_unit #(
   parameter int MAX_SIDE = 768,
   parameter int MAX_RADIUS = 15
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic               req_mode,
   input  wire logic signed [15:0] req_primary_alpha,
   input  wire logic signed [15:0] req_secondary_alpha,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic signed [15:0]      rsp_fused_alpha,
   output logic                    rsp_end_of_frame,
   input  wire logic               csr_write_en,
   input  wire logic [2:0]         csr_index,
   input  wire logic [12:0]        csr_wdata
);
   import dem_pkg::*;

   localparam int SEC_DEPTH = (2 * MAX_RADIUS + 1) * MAX_SIDE;
   localparam int PRI_DEPTH = MAX_RADIUS * MAX_SIDE + MAX_RADIUS + 1;
   localparam int SAW = $clog2(SEC_DEPTH);
   localparam int PAW = $clog2(PRI_DEPTH);

   logic [12:0] cols_ff, rows_ff, core_thr_ff, weak_thr_ff;
   logic [3:0]  radius_ff;
   logic        settle_ff;
   cfg_type     cfg;

   logic        accept;
   logic        job_push, job_pop, job_empty, job_full;
   job_type     job_new, job_head;
   logic        out_push, out_full;
   result_type  out_item, out_head;
   logic        back_idle;

   logic           sec_we, pri_we;
   logic [SAW-1:0] sec_waddr, sec_raddr;
   logic [PAW-1:0] pri_waddr, pri_raddr;
   logic [12:0]    sec_wdata, sec_rdata;
   logic [15:0]    pri_wdata, pri_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= 13'd768;
         rows_ff <= 13'd768;
         radius_ff <= '0;
         core_thr_ff <= 13'd2048;
         weak_thr_ff <= 13'd2048;
         settle_ff <= 1'b0;
      end else begin
         settle_ff <= csr_write_en;
         if (csr_write_en) begin
            case (csr_index)
               CSR_COLUMNS:  cols_ff <= csr_wdata;
               CSR_ROWS:     rows_ff <= csr_wdata;
               CSR_RADIUS:   radius_ff <= csr_wdata[3:0];
               CSR_CORE_THR: core_thr_ff <= csr_wdata;
               CSR_WEAK_THR: weak_thr_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_comb begin
      cfg.cols = (cols_ff == '0) ? 13'd1 : cols_ff;
      cfg.rows = (rows_ff == '0) ? 13'd1 : rows_ff;
      cfg.radius = ({2'b00, radius_ff} > 6'(MAX_RADIUS)) ? 4'(MAX_RADIUS) : radius_ff;
      cfg.core_thr = core_thr_ff;
      cfg.weak_thr = weak_thr_ff;
   end

   // An item is taken only when nothing is in flight, so the stores never move under a scan.
   assign req_full = !(job_empty && back_idle) || settle_ff;
   assign accept = req_push && !req_full;

   dem_front #(
      .MAX_SIDE  (MAX_SIDE),
      .SEC_DEPTH (SEC_DEPTH),
      .PRI_DEPTH (PRI_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .accept          (accept),
      .mode            (req_mode),
      .primary_alpha   (req_primary_alpha),
      .secondary_alpha (req_secondary_alpha),
      .job_push        (job_push),
      .job             (job_new),
      .sec_we          (sec_we),
      .sec_waddr       (sec_waddr),
      .sec_wdata       (sec_wdata),
      .pri_we          (pri_we),
      .pri_waddr       (pri_waddr),
      .pri_wdata       (pri_wdata)
   );

   dem_fifo #(
      .WIDTH  ($bits(job_type)),
      .ADDR_W (1)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_new),
      .pop       (job_pop),
      .head      (job_head),
      .empty     (job_empty),
      .full      (job_full)
   );

   dem_ram #(
      .WIDTH (13),
      .DEPTH (SEC_DEPTH)
   ) u_sec_store (
      .clock   (clock),
      .wr_en   (sec_we),
      .wr_addr (sec_waddr),
      .wr_data (sec_wdata),
      .rd_addr (sec_raddr),
      .rd_data (sec_rdata)
   );

   dem_ram #(
      .WIDTH (16),
      .DEPTH (PRI_DEPTH)
   ) u_pri_store (
      .clock   (clock),
      .wr_en   (pri_we),
      .wr_addr (pri_waddr),
      .wr_data (pri_wdata),
      .rd_addr (pri_raddr),
      .rd_data (pri_rdata)
   );

   dem_back #(
      .SEC_DEPTH (SEC_DEPTH),
      .PRI_DEPTH (PRI_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .job_empty (job_empty),
      .job       (job_head),
      .job_pop   (job_pop),
      .sec_raddr (sec_raddr),
      .sec_rdata (sec_rdata),
      .pri_raddr (pri_raddr),
      .pri_rdata (pri_rdata),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_item  (out_item),
      .idle      (back_idle)
   );

   dem_fifo #(
      .WIDTH  ($bits(result_type)),
      .ADDR_W (1)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_item),
      .pop       (rsp_pop),
      .head      (out_head),
      .empty     (rsp_empty),
      .full      (out_full)
   );

   assign rsp_fused_alpha = out_head.fused;
   assign rsp_end_of_frame = out_head.eof;

   `DEM_ASSERT_IMPLY(a_job_room, clock, reset, job_push, !job_full && job_empty)
   `DEM_ASSERT_IMPLY(a_accept_idle, clock, reset, accept, back_idle)
   `DEM_ASSERT_IMPLY(a_rsp_room, clock, reset, out_push, !out_full)
endmodule
`default_nettype wire

// ===== tb/disk_erode_mask_fusion_checker.sv =====
`default_nettype none
module disk_erode_mask_fusion_checker
   import dem_pkg::*;
#(
   parameter int MAX_SIDE = 768,
   parameter int MAX_RADIUS = 15
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   input  wire logic               req_full,
   input  wire logic               req_mode,
   input  wire logic signed [15:0] req_primary_alpha,
   input  wire logic signed [15:0] req_secondary_alpha,
   input  wire logic               rsp_empty,
   input  wire logic               rsp_pop,
   input  wire logic signed [15:0] rsp_fused_alpha,
   input  wire logic               rsp_end_of_frame,
   input  wire logic               csr_write_en,
   input  wire logic [2:0]         csr_index,
   input  wire logic [12:0]        csr_wdata,
   output int                      mismatches,
   output int                      outstanding
);

   localparam int LINE_DEPTH = (2 * MAX_RADIUS + 1) * MAX_SIDE;
   localparam int DELAY_DEPTH = MAX_RADIUS * MAX_SIDE + MAX_RADIUS + 1;
   localparam int UNIT = 4096;

   typedef struct packed {
      logic signed [15:0] alpha;
      logic               eof;
   } fused_item_t;

   fused_item_t fused_q[$];

   logic [12:0] cols, rows, cthr, wthr;
   logic [3:0]  radius;
   logic [12:0] sec_line [LINE_DEPTH];
   logic [15:0] pri_line [DELAY_DEPTH];
   int unsigned pix_in, pix_out;

   function automatic int unsigned sat_alpha(input logic signed [15:0] v);
      if (v < 0) return 0;
      if (v > UNIT) return UNIT;
      return int'(v);
   endfunction

   function automatic int unsigned ease(input int unsigned t);
      longint unsigned tt;
      tt = t;
      return int'((tt * tt * longint'(3 * UNIT - 2 * t)) >> 24);
   endfunction

   function automatic int unsigned blend_alpha(input int unsigned p, input int unsigned c);
      int unsigned ct, wt, strength, weakness, t, mix, target;
      ct = (cthr > UNIT) ? UNIT : cthr;
      wt = (wthr > UNIT) ? UNIT : wthr;
      if (c < ct || p >= wt) return p;
      if (ct == UNIT) begin
         strength = UNIT;
      end else begin
         t = ((c - ct) * UNIT) / (UNIT - ct);
         if (t > UNIT) t = UNIT;
         strength = ease(t);
      end
      t = (p * UNIT) / wt;
      if (t > UNIT) t = UNIT;
      weakness = UNIT - ease(t);
      mix = (strength * weakness) / UNIT;
      if (mix > UNIT) mix = UNIT;
      target = (p > c) ? p : c;
      return (p * (UNIT - mix) + target * mix) / UNIT;
   endfunction

   // Minimum over the disk, clipped at the frame edges.
   function automatic int unsigned eroded_core(input int unsigned k, input int unsigned w,
                                               input int unsigned h, input int unsigned r);
      int unsigned x, y, y0, y1, x0, x1, m, dx, dy;
      x = k % w;
      y = k / w;
      y0 = (y > r) ? y - r : 0;
      y1 = (y + r < h) ? y + r : h - 1;
      x0 = (x > r) ? x - r : 0;
      x1 = (x + r < w) ? x + r : w - 1;
      m = UNIT;
      if (r == 0) return sec_line[k % LINE_DEPTH];
      for (int unsigned yy = y0; yy <= y1; yy++) begin
         dy = (yy > y) ? yy - y : y - yy;
         for (int unsigned xx = x0; xx <= x1; xx++) begin
            dx = (xx > x) ? xx - x : x - xx;
            if (dx * dx + dy * dy <= r * r && sec_line[(yy * w + xx) % LINE_DEPTH] < m)
               m = sec_line[(yy * w + xx) % LINE_DEPTH];
         end
      end
      return m;
   endfunction

   task automatic take_item(input logic mode, input logic [15:0] pa, input logic [15:0] sa);
      int unsigned w, h, n, r, k, need, p, c;
      fused_item_t item;
      w = (cols != 0) ? cols : 1;
      h = (rows != 0) ? rows : 1;
      n = w * h;
      r = (radius > MAX_RADIUS) ? MAX_RADIUS : radius;
      if (pix_out >= n || pix_in > n) begin
         pix_in = 0;
         pix_out = 0;
      end
      if (w > MAX_SIDE || h > MAX_SIDE) begin
         if (mode == 1'b0) begin
            pix_out++;
            item.alpha = pa;
            item.eof = (pix_out == n);
            if (pix_out == n) pix_out = 0;
            pix_in = pix_out;
            fused_q.push_back(item);
         end
         return;
      end
      if (mode == 1'b0 && pix_in < n) begin
         sec_line[pix_in % LINE_DEPTH] = 13'(sat_alpha(sa));
         pri_line[pix_in % DELAY_DEPTH] = pa;
         pix_in++;
      end
      if (pix_out < pix_in) begin
         k = pix_out;
         need = k + r * w + r + 1;
         if (need > n) need = n;
         if (pix_in >= need) begin
            p = sat_alpha(pri_line[k % DELAY_DEPTH]);
            c = eroded_core(k, w, h, r);
            item.alpha = 16'(blend_alpha(p, c));
            item.eof = (k + 1 == n);
            fused_q.push_back(item);
            pix_out++;
            if (pix_out == n) begin
               pix_in = 0;
               pix_out = 0;
            end
         end
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      fused_item_t want;
      if (reset) begin
         cols = 13'd768;
         rows = 13'd768;
         radius = '0;
         cthr = 13'd2048;
         wthr = 13'd2048;
         pix_in = 0;
         pix_out = 0;
         fused_q.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_COLUMNS:  cols = csr_wdata;
               CSR_ROWS:     rows = csr_wdata;
               CSR_RADIUS:   radius = csr_wdata[3:0];
               CSR_CORE_THR: cthr = csr_wdata;
               CSR_WEAK_THR: wthr = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_pop && !rsp_empty) begin
            if (fused_q.size() == 0) begin
               report_mismatch($sformatf("result %0d with nothing expected", rsp_fused_alpha));
            end else begin
               want = fused_q.pop_front();
               if (rsp_fused_alpha !== want.alpha)
                  report_mismatch($sformatf("fused_alpha %0d, expected %0d",
                                            rsp_fused_alpha, want.alpha));
               if (rsp_end_of_frame !== want.eof)
                  report_mismatch($sformatf("end_of_frame %0b, expected %0b",
                                            rsp_end_of_frame, want.eof));
            end
         end
         if (req_push && !req_full)
            take_item(req_mode, req_primary_alpha, req_secondary_alpha);
      end
      outstanding = fused_q.size();
   end

   initial begin
      mismatches = 0;
      outstanding = 0;
   end

endmodule
`default_nettype wire

// ===== tb/tb_disk_erode_mask_fusion_unit.sv =====
`default_nettype none
module tb_disk_erode_mask_fusion_unit;
   import dem_pkg::*;

   localparam logic [2:0] CSR_SPARE = 3'd7;
   localparam int ITEM_TARGET = 620;
   localparam int STALL_LIMIT = 40000;

   logic               clock;
   logic               reset;
   logic               req_push;
   logic               req_full;
   logic               req_mode;
   logic signed [15:0] req_primary_alpha;
   logic signed [15:0] req_secondary_alpha;
   logic               rsp_empty;
   logic               rsp_pop;
   logic signed [15:0] rsp_fused_alpha;
   logic               rsp_end_of_frame;
   logic               csr_write_en;
   logic [2:0]         csr_index;
   logic [12:0]        csr_wdata;

   int mismatches, outstanding;
   int gap_pct, stall_pct, sent, quiet_cycles;

   disk_erode_mask_fusion_unit u_dut (
      .clock, .reset, .req_push, .req_full, .req_mode, .req_primary_alpha,
      .req_secondary_alpha, .rsp_empty, .rsp_pop, .rsp_fused_alpha, .rsp_end_of_frame,
      .csr_write_en, .csr_index, .csr_wdata
   );

   disk_erode_mask_fusion_checker u_check (
      .clock, .reset, .req_push, .req_full, .req_mode, .req_primary_alpha,
      .req_secondary_alpha, .rsp_empty, .rsp_pop, .rsp_fused_alpha, .rsp_end_of_frame,
      .csr_write_en, .csr_index, .csr_wdata, .mismatches, .outstanding
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[disk_erode_mask_fusion_unit] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [15:0] pick_alpha();
      case ($urandom_range(7))
         0: return 16'($urandom);
         1: case ($urandom_range(5))
               0: return 16'h8000;
               1: return 16'h7fff;
               2: return 16'hffff;
               3: return 16'd4097;
               4: return 16'd4096;
               default: return 16'd0;
            endcase
         default: return 16'($urandom_range(0, 4096));
      endcase
   endfunction

   function automatic logic [12:0] pick_threshold();
      case ($urandom_range(7))
         0: return 13'd0;
         1: return 13'd4096;
         2: return 13'h1fff;
         default: return 13'($urandom_range(0, 4096));
      endcase
   endfunction

   task automatic pick_idling(input int phase);
      case (phase % 4)
         0: begin gap_pct = 0;  stall_pct = 0;  end
         1: begin gap_pct = 65; stall_pct = 0;  end
         2: begin gap_pct = 0;  stall_pct = 65; end
         default: begin gap_pct = 7; stall_pct = 7; end
      endcase
   endtask

   task automatic push_item(input logic m, input logic [15:0] pa, input logic [15:0] sa);
      if ($urandom_range(99) < gap_pct) begin
         req_push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_push <= 1'b1;
      req_mode <= m;
      req_primary_alpha <= pa;
      req_secondary_alpha <= sa;
      do @(posedge clock); while (req_full);
      sent++;
   endtask

   // Registers may only change once every pending result has been taken.
   task automatic wait_idle();
      req_push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [12:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic configure(input logic [12:0] c, input logic [12:0] r, input logic [3:0] rad,
                            input logic [12:0] ct, input logic [12:0] wt);
      wait_idle();
      csr_write(CSR_COLUMNS, c);
      csr_write(CSR_ROWS, r);
      csr_write(CSR_RADIUS, 13'(rad));
      csr_write(CSR_CORE_THR, ct);
      csr_write(CSR_WEAK_THR, wt);
      if ($urandom_range(3) == 0) csr_write(CSR_SPARE, 13'($urandom));
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // A frame of pixels, then enough drain transfers to flush what is pending.
   task automatic run_frame(input int w, input int h, input int r);
      int n, drains;
      n = w * h;
      drains = r * w + r + 1;
      if (drains > n) drains = n;
      for (int i = 0; i < n; i++) push_item(1'b0, pick_alpha(), pick_alpha());
      for (int i = 0; i < drains; i++)
         push_item(($urandom_range(3) != 0), pick_alpha(), pick_alpha());
      for (int i = $urandom_range(2); i > 0; i--) push_item(1'b1, pick_alpha(), pick_alpha());
   endtask

   initial begin
      int w, h, r, frame_no;
      reset = 1'b1;
      req_push = 1'b0;
      req_mode = 1'b0;
      req_primary_alpha = '0;
      req_secondary_alpha = '0;
      rsp_pop = 1'b0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      gap_pct = 0;
      stall_pct = 0;
      sent = 0;
      quiet_cycles = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      configure(13'd2, 13'd2, 4'd0, 13'd0, 13'd4096);
      push_item(1'b0, 16'h8000, 16'h7fff);
      push_item(1'b0, 16'h7fff, 16'h8000);
      push_item(1'b0, 16'd0, 16'd4096);
      push_item(1'b0, 16'd4096, 16'd4097);

      // Full radius on a tiny frame, with saturating and top thresholds.
      configure(13'd3, 13'd2, 4'd15, 13'd4096, 13'h1fff);
      run_frame(3, 2, 15);
      push_item(1'b0, 16'd100, 16'd4000);

      // Zero-sized frame acts as a single pixel; an extra drain finds nothing.
      configure(13'd0, 13'd0, 4'd1, 13'h1fff, 13'd0);
      push_item(1'b0, 16'd2000, 16'd3000);
      push_item(1'b1, 16'd0, 16'd0);

      // Oversized frames pass the raw primary through.
      configure(13'h1fff, 13'h1fff, 4'd0, 13'd2048, 13'd2048);
      push_item(1'b0, 16'h8001, 16'd5);
      push_item(1'b1, 16'd7, 16'd7);
      push_item(1'b0, 16'h1234, 16'd5);
      configure(13'd769, 13'd1, 4'd0, 13'd2048, 13'd2048);
      push_item(1'b0, 16'hfedc, 16'd5);

      // A frame left half done is abandoned once the size shrinks below the counts.
      configure(13'd4, 13'd4, 4'd0, 13'd1000, 13'd3000);
      for (int i = 0; i < 5; i++) push_item(1'b0, pick_alpha(), pick_alpha());
      configure(13'd2, 13'd2, 4'd0, 13'd1000, 13'd3000);
      run_frame(2, 2, 0);

      frame_no = 0;
      while (sent < ITEM_TARGET) begin
         pick_idling(frame_no);
         frame_no++;
         if ($urandom_range(9) == 0) begin
            configure(13'($urandom_range(769, 8191)), 13'($urandom_range(0, 8191)),
                      4'($urandom), pick_threshold(), pick_threshold());
            for (int i = $urandom_range(1, 8); i > 0; i--)
               push_item(1'($urandom), pick_alpha(), pick_alpha());
         end else begin
            if ($urandom_range(9) == 0) begin
               r = 15;
               w = $urandom_range(1, 4);
               h = $urandom_range(1, 4);
            end else begin
               r = $urandom_range(0, 4);
               w = $urandom_range(1, 12);
               h = $urandom_range(1, 8);
            end
            configure((w == 1 && $urandom_range(1) == 0) ? 13'd0 : 13'(w),
                      (h == 1 && $urandom_range(1) == 0) ? 13'd0 : 13'(h),
                      4'(r), pick_threshold(), pick_threshold());
            run_frame(w, h, r);
         end
      end

      pick_idling(2);
      wait_idle();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("[disk_erode_mask_fusion_unit] OK");
      end else begin
         $display("[disk_erode_mask_fusion_unit] ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
